[src/pngu_pkg.sv]
// Shared constants and types for the PNG indexed row unfilter.
package pngu_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_PALETTE_SIZE = 256;

    // Stream word widths
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_ALPHA    = 2'd2;

    localparam int IMAGE_WIDTH_W  = 13;
    localparam int IMAGE_HEIGHT_W = 16;

    // Input word kinds (tuser)
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // Row filter types
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] FILT_MAX_BYTE = 8'd4;

    // Alpha byte values
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Reconstructed pixel on its way to the palette stage
    typedef struct packed {
        logic [7:0] pix;
        logic       in_range;
        logic       row_last;
        logic       image_last;
        logic       bad;
    } pixel_info_t;

endpackage

[src/png_indexed_row_unfilter.sv]
// Top level: PNG 8-bit indexed scanline unfilter with line buffer and palette lookup.
// An accepted pixel byte passes the input register, then the palette stage register, then the
// output register; each of these holds its word while the stage after it is not free.
// Throughput: one input word per cycle while the output is not stalled; the left-neighbour loop
// closes through the reconstruct stage and each RAM is read once per pixel.
// Reset (aresetn low, synchronous): counters, filter state and config return to defaults,
// the line buffer fill count clears so it reads as zeros; palette is undefined until written.
module png_indexed_row_unfilter #(
    parameter int MAX_WIDTH    = pngu_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_SIZE = pngu_pkg::DEF_PALETTE_SIZE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // palette_index[7:0], palette_rgb[31:8], data_byte[39:32]
    input  logic [pngu_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  logic [pngu_pkg::S_USER_W-1:0]    s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_color[31:0], pixel_index[39:32]
    output logic [pngu_pkg::M_DATA_W-1:0]    m_tdata,
    // image_last[0], bad_filter[1]
    output logic [pngu_pkg::M_USER_W-1:0]    m_tuser,
    output logic                             m_tlast,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pngu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import pngu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = $clog2(PALETTE_SIZE);

    typedef struct packed {
        logic [7:0]    raw;
        logic [AW-1:0] x;
        logic [2:0]    filter;
        logic          bad;
        logic          above_zero;
        logic          row_last;
        logic          image_last;
    } recon_t;

    // Paeth predictor on one byte per pixel
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] d_bc;
        logic signed [9:0] d_ac;
        logic signed [9:0] d_sum;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
        d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
        d_sum = d_bc + d_ac;
        pa    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
        pb    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
        pc    = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

    // input word fields
    logic        in_req;
    logic [7:0]  in_pal_index;
    logic [23:0] in_pal_rgb;
    logic [7:0]  in_byte;

    assign in_req       = s_tuser[0];
    assign in_pal_index = s_tdata[7:0];
    assign in_pal_rgb   = s_tdata[31:8];
    assign in_byte      = s_tdata[39:32];

    // configuration registers
    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;
    logic                      use_alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_W'(1);
            image_height_reg <= IMAGE_HEIGHT_W'(1);
            use_alpha_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMAGE_HEIGHT_W-1:0];
                REG_USE_ALPHA:    use_alpha_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, width saturates at the buffer size
    logic [CW-1:0]             width_eff;
    logic [IMAGE_HEIGHT_W-1:0] height_m1;

    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = CW'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(image_width_reg);
        end
        height_m1 = (image_height_reg == '0) ? '0 : image_height_reg - 1'b1;
    end

    // pipeline handshake
    logic   s1_valid_reg;
    logic   s2_valid_reg;
    logic   m_valid_reg;
    logic   out_free;
    logic   s2_free;
    logic   s2_fire;
    logic   s1_fire;
    logic   s_accept;
    logic   in_pixel;
    logic   in_filter;

    assign out_free  = !m_valid_reg || m_tready;
    assign s2_fire   = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_fire   = s1_valid_reg && s2_free;
    assign s_tready  = !s1_valid_reg || s2_free;
    assign s_accept  = s_tvalid && s_tready;

    // row / column bookkeeping, done at acceptance
    logic [CW-1:0]             col_reg;
    logic [IMAGE_HEIGHT_W-1:0] row_reg;
    logic [2:0]                row_filter_reg;
    logic                      row_bad_reg;
    logic [CW-1:0]             fill_reg;
    logic [CW-1:0]             col_m1;
    logic [AW-1:0]             x_cur;
    logic                      cur_row_last;
    logic                      cur_image_last;
    logic                      cur_above_zero;

    assign in_filter      = (in_req == REQ_PIXEL) && (col_reg == '0);
    assign in_pixel       = (in_req == REQ_PIXEL) && (col_reg != '0);
    assign col_m1         = col_reg - CW'(1);
    assign x_cur          = col_m1[AW-1:0];
    assign cur_row_last   = col_reg >= width_eff;
    assign cur_image_last = cur_row_last && (row_reg >= height_m1);
    assign cur_above_zero = (row_reg == '0) || (col_m1 >= fill_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            row_filter_reg <= FILT_NONE;
            row_bad_reg    <= 1'b0;
        end else if (s_accept) begin
            if (in_filter) begin
                row_bad_reg    <= in_byte > FILT_MAX_BYTE;
                row_filter_reg <= (in_byte > FILT_MAX_BYTE) ? FILT_NONE : in_byte[2:0];
                col_reg        <= CW'(1);
            end else if (in_pixel) begin
                if (cur_row_last) begin
                    col_reg <= '0;
                    row_reg <= cur_image_last ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    // input stage register
    recon_t s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= in_pixel;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && in_pixel) begin
            s1_reg.raw        <= in_byte;
            s1_reg.x          <= x_cur;
            s1_reg.filter     <= row_filter_reg;
            s1_reg.bad        <= row_bad_reg;
            s1_reg.above_zero <= cur_above_zero;
            s1_reg.row_last   <= cur_row_last;
            s1_reg.image_last <= cur_image_last;
        end
    end

    // line buffer: read at acceptance, written when the pixel is rebuilt
    logic [7:0] line_q;
    logic [7:0] pix;

    pngu_ram #(
        .DATA_W (8),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (AW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (s1_reg.x),
        .wdata (pix),
        .re    (s_accept && in_pixel),
        .raddr (x_cur),
        .rdata (line_q)
    );

    // written prefix of the line buffer; columns are always written from zero upward
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s1_fire && (CW'(s1_reg.x) == fill_reg)) begin
            fill_reg <= fill_reg + CW'(1);
        end
    end

    // reconstruct stage
    logic [7:0] left_reg;
    logic [7:0] upleft_reg;
    logic [7:0] above;
    logic [7:0] left_eff;
    logic [7:0] upleft_eff;
    logic [7:0] pred;
    logic [8:0] avg_sum;

    always_comb begin
        above      = s1_reg.above_zero ? 8'd0 : line_q;
        left_eff   = (s1_reg.x == '0) ? 8'd0 : left_reg;
        upleft_eff = (s1_reg.x == '0) ? 8'd0 : upleft_reg;
        avg_sum    = {1'b0, left_eff} + {1'b0, above};
        case (s1_reg.filter)
            FILT_SUB:   pred = left_eff;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(left_eff, above, upleft_eff);
            default:    pred = 8'd0;
        endcase
        pix = s1_reg.raw + pred;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            upleft_reg <= '0;
        end else if (s1_fire) begin
            left_reg   <= pix;
            upleft_reg <= above;
        end
    end

    // palette: written at acceptance, read by the rebuilt index
    logic [23:0] pal_q;

    pngu_ram #(
        .DATA_W (24),
        .DEPTH  (PALETTE_SIZE),
        .ADDR_W (PW)
    ) u_palette_ram (
        .aclk  (aclk),
        .we    (s_accept && (in_req == REQ_PALETTE) && (9'(in_pal_index) < 9'(PALETTE_SIZE))),
        .waddr (in_pal_index[PW-1:0]),
        .wdata (in_pal_rgb),
        .re    (s1_fire),
        .raddr (pix[PW-1:0]),
        .rdata (pal_q)
    );

    // palette stage register
    pixel_info_t s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_fire) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            s2_reg.pix        <= pix;
            s2_reg.in_range   <= 9'(pix) < 9'(PALETTE_SIZE);
            s2_reg.row_last   <= s1_reg.row_last;
            s2_reg.image_last <= s1_reg.image_last;
            s2_reg.bad        <= s1_reg.bad;
        end
    end

    // output register: colour formed from the palette word
    logic [31:0] color;
    logic [31:0] m_color_reg;
    logic [7:0]  m_index_reg;
    logic        m_row_last_reg;
    logic        m_image_last_reg;
    logic        m_bad_reg;

    always_comb begin
        color[23:0]  = s2_reg.in_range ? pal_q : 24'd0;
        color[31:24] = (use_alpha_reg && (s2_reg.pix == 8'd0)) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            m_color_reg      <= color;
            m_index_reg      <= s2_reg.pix;
            m_row_last_reg   <= s2_reg.row_last;
            m_image_last_reg <= s2_reg.image_last;
            m_bad_reg        <= s2_reg.bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_index_reg, m_color_reg};
    assign m_tuser  = {m_bad_reg, m_image_last_reg};
    assign m_tlast  = m_row_last_reg;

endmodule

[src/pngu_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
module pngu_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/png_indexed_row_unfilter_tb.sv]
// Testbench for png_indexed_row_unfilter: streams palette and image words, predicts every pixel.
module png_indexed_row_unfilter_tb;
    import pngu_pkg::*;

    localparam int MAXW  = DEF_MAX_WIDTH;
    localparam int PAL   = DEF_PALETTE_SIZE;
    localparam int DRAIN = 8;      // covers the input, palette stage and output registers, with some margin
    localparam int LIMIT = 1000;   // cycles without any handshake before giving up

    // Three 3-pixel rows per image, two images: every filter, both extremes, a bad filter row
    localparam bit [7:0] DIRECTED_ROWS [24] = '{
        FILT_NONE,  8'h00, 8'hFF, 8'h80,
        FILT_SUB,   8'h01, 8'hFF, 8'h00,
        FILT_UP,    8'hFF, 8'h01, 8'h80,
        8'h05,      8'h00, 8'h05, 8'hFF,
        FILT_AVG,   8'h03, 8'hC8, 8'hFF,
        FILT_PAETH, 8'h00, 8'h11, 8'hFF
    };

    typedef struct {
        bit [31:0] color;
        bit [7:0]  index;
        bit        row_last;
        bit        image_last;
        bit        bad;
    } pixel_t;

    // Tracks palette and row state, works out each pixel and checks the result words
    class pixel_scoreboard;
        bit [23:0]   palette [PAL];
        bit [7:0]    line_buf [MAXW];
        bit [7:0]    left_pix, upleft_pix;
        int unsigned column, row;
        bit [2:0]    filter;
        bit          filter_bad;
        int unsigned width_reg, height_reg;
        bit          alpha_on;
        pixel_t      pixels_due [$];
        int unsigned mismatches, pixels_seen, palette_writes, bad_pixels, clear_pixels;

        function new();
            foreach (line_buf[i]) line_buf[i] = '0;
            width_reg  = 1;
            height_reg = 1;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = value[IMAGE_HEIGHT_W-1:0];
                REG_USE_ALPHA:    alpha_on   = value[0];
                default: ;
            endcase
        endfunction

        function bit [7:0] above_pix();
            int unsigned x;
            x = column - 1;
            return (row == 0 || x >= MAXW) ? 8'h00 : line_buf[x];
        endfunction

        function bit [7:0] paeth(bit [7:0] a, bit [7:0] b, bit [7:0] c);
            int ia, ib, ic, p, pa, pb, pc;
            ia = a;
            ib = b;
            ic = c;
            p  = ia + ib - ic;
            pa = p - ia; if (pa < 0) pa = -pa;
            pb = p - ib; if (pb < 0) pb = -pb;
            pc = p - ic; if (pc < 0) pc = -pc;
            if (pa <= pb && pa <= pc) return a;
            if (pb <= pc) return b;
            return c;
        endfunction

        // Predictor for the next pixel byte of the current row
        function bit [7:0] prediction();
            bit [7:0] up;
            up = above_pix();
            case (filter)
                FILT_SUB:   return left_pix;
                FILT_UP:    return up;
                FILT_AVG:   return 8'(({1'b0, left_pix} + {1'b0, up}) >> 1);
                FILT_PAETH: return paeth(left_pix, up, upleft_pix);
                default:    return 8'h00;
            endcase
        endfunction

        // Raw byte that reconstructs to index 0
        function bit [7:0] zero_raw();
            return 8'h00 - prediction();
        endfunction

        function void take_word(bit req, bit [7:0] idx, bit [23:0] rgb, bit [7:0] data);
            int unsigned w, h, x;
            bit [7:0] up, pix;
            pixel_t   px;
            if (req == REQ_PALETTE) begin
                if (idx < PAL) palette[idx] = rgb;
                palette_writes++;
                return;
            end
            // filter byte opens the row
            if (column == 0) begin
                filter_bad = data > FILT_MAX_BYTE;
                filter     = filter_bad ? FILT_NONE : data[2:0];
                left_pix   = '0;
                upleft_pix = '0;
                column     = 1;
                return;
            end
            w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            x   = column - 1;
            up  = above_pix();
            pix = data + prediction();
            if (x < MAXW) line_buf[x] = pix;
            left_pix   = pix;
            upleft_pix = up;
            px.color      = {ALPHA_OPAQUE, (pix < PAL) ? palette[pix] : 24'h0};
            if (alpha_on && pix == 0) px.color[31:24] = ALPHA_CLEAR;
            px.index      = pix;
            px.row_last   = (x + 1) >= w;
            px.image_last = px.row_last && (row + 1) >= h;
            px.bad        = filter_bad;
            if (px.row_last) begin
                column = 0;
                row    = px.image_last ? 0 : ((row + 1) & 16'hFFFF);
            end else begin
                column = x + 2;
            end
            if (px.bad) bad_pixels++;
            if (px.color[31:24] == ALPHA_CLEAR) clear_pixels++;
            pixels_due.push_back(px);
        endfunction

        function void compare(string field, bit [31:0] want, bit [31:0] got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: %s expected %h, got %h", pixels_seen, field, want, got);
            end
        endfunction

        function void check_pixel(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user,
                                  logic last);
            pixel_t px;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %h with no pixel pending", data);
                return;
            end
            px = pixels_due.pop_front();
            compare("pixel_color", px.color, data[31:0]);
            compare("pixel_index", px.index, data[39:32]);
            compare("row_last", px.row_last, last);
            compare("image_last", px.image_last, user[0]);
            compare("bad_filter", px.bad, user[1]);
            pixels_seen++;
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [S_USER_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [M_USER_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pixel_scoreboard board = new();
    bit          in_idle  = 1'b1;
    bit          out_idle = 1'b1;
    int unsigned quiet_cycles;
    int unsigned reg_writes;

    png_indexed_row_unfilter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input side: optional gap, then hold the word until it is taken
    task automatic send_word(bit req, bit [7:0] idx, bit [23:0] rgb, bit [7:0] data);
        int gap;
        gap = in_idle ? $urandom_range(0, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {data, rgb, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_word(req, idx, rgb, data);
    endtask

    task automatic send_image_byte(bit [7:0] data);
        send_word(REQ_PIXEL, 8'($urandom), 24'($urandom), data);
    endtask

    task automatic send_palette(bit [7:0] idx, bit [23:0] rgb);
        send_word(REQ_PALETTE, idx, rgb, 8'($urandom));
    endtask

    task automatic send_pixels(int unsigned count);
        repeat (count) send_image_byte(8'($urandom));
    endtask

    // Stop sending and wait until every pixel is out and the pipe has gone quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pixels_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_reg(idx, value);
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h, bit alpha);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_USE_ALPHA, {15'd0, alpha});
    endtask

    // Either side may idle, both, or neither
    task automatic pick_idling();
        in_idle  = $urandom_range(0, 2) != 0;
        out_idle = $urandom_range(0, 2) != 0;
    endtask

    // Result side: random stall per word, then ready until a word is taken
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = out_idle ? $urandom_range(0, 3) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_pixel(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                     LIMIT, board.pixels_due.size());
            $display("png_indexed_row_unfilter regression: fail");
            $finish;
        end
    end

    initial begin
        bit [7:0]  filt;
        bit [23:0] shade;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Every palette entry is written before any pixel can look it up
        for (int i = 0; i < PAL; i++) begin
            shade = (i == 0) ? 24'h000000 : ((i == PAL - 1) ? 24'hFFFFFF : 24'($urandom));
            send_palette(8'(i), shade);
        end

        // Directed: each filter, field extremes, bad filter, transparent index 0
        configure(3, 3, 1'b1);
        foreach (DIRECTED_ROWS[i]) send_image_byte(DIRECTED_ROWS[i]);

        // Width and height changed part-way through a row and an image
        configure(6, 2, 1'b1);
        send_image_byte(8'hFF);
        send_pixels(3);
        settle();
        write_reg(REG_IMAGE_WIDTH, 2);
        send_pixels(1);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 1);
        send_image_byte(FILT_UP);
        send_pixels(2);

        // Zero width and height act as one
        configure(0, 0, 1'b0);
        repeat (6) begin
            send_image_byte(8'($urandom_range(0, 5)));
            send_pixels(1);
        end

        // Random: rows of random content under random settings, palette rewrites mixed in
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 5))
                0:       shade[15:0] = 1;
                1:       shade[15:0] = 2;
                2:       shade[15:0] = 0;
                3:       shade[15:0] = 16'($urandom_range(3, 16));
                4:       shade[15:0] = 16'($urandom_range(17, 80));
                default: shade[15:0] = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 4))
                0:       configure(shade[15:0], 0, 1'($urandom));
                1:       configure(shade[15:0], 1, 1'($urandom));
                2:       configure(shade[15:0], 16'hFFFF, 1'($urandom));
                default: configure(shade[15:0], 16'($urandom_range(2, 6)), 1'($urandom));
            endcase
            for (int n = 0; n < 90; n++) begin
                if (n % 25 == 0) pick_idling();
                if ($urandom_range(0, 7) == 0) begin
                    send_palette(8'($urandom), 24'($urandom));
                end else if (board.column == 0) begin
                    filt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255))
                                                       : 8'($urandom_range(0, 4));
                    send_image_byte(filt);
                end else if ($urandom_range(0, 15) == 0) begin
                    send_image_byte(board.zero_raw());
                end else begin
                    send_image_byte(8'($urandom));
                end
            end
        end

        settle();
        $display("covered %0d pixels (%0d in bad-filter rows, %0d transparent), %0d palette writes",
                 board.pixels_seen, board.bad_pixels, board.clear_pixels, board.palette_writes);
        $display("over %0d register writes: zero, short and mid-row widths, wrapping images",
                 reg_writes);
        if (board.mismatches == 0 && board.pixels_due.size() == 0) begin
            $display("png_indexed_row_unfilter regression: pass");
        end else begin
            $display("%0d mismatches, %0d pixels never arrived",
                     board.mismatches, board.pixels_due.size());
            $display("png_indexed_row_unfilter regression: fail");
        end
        $finish;
    end

endmodule
